### hdl/assert_macros.svh
// Assertion macros shared by the drive safety supervisor RTL.
// Each macro expects clk_i and rst_ni in scope of the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dss_pkg.sv
// Types and constants of the drive safety supervisor.
// No dependencies; used by dss_step and drive_safety_supervisor.
`timescale 1ns / 1ps

package dss_pkg;

  // Operating mode codes
  localparam logic [3:0] ModeBoot     = 4'd0;
  localparam logic [3:0] ModeDisabled = 4'd1;
  localparam logic [3:0] ModeReady    = 4'd2;
  localparam logic [3:0] ModeForward  = 4'd3;
  localparam logic [3:0] ModeReverse  = 4'd4;
  localparam logic [3:0] ModeLeft     = 4'd5;
  localparam logic [3:0] ModeRight    = 4'd6;
  localparam logic [3:0] ModeObstacle = 4'd7;
  localparam logic [3:0] ModeFault    = 4'd8;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] RegMotionThreshold = 4'd0;
  localparam logic [CfgIdxW-1:0] RegObstacleHoldMs  = 4'd1;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [14:0] ThresholdReset = 15'd50;
  localparam logic [15:0] HoldReset      = 16'd1000;

  // Stream widths (fields packed low to high, padded to bytes)
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 40;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic               subsystem_fault;
    logic [7:0]         bumper_alert_mask;
    logic               bumpers_released;
    logic               activation;
    logic signed [15:0] request_left;
    logic signed [15:0] request_right;
  } dss_item_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
    logic               drive_enable;
    logic               mode_changed;
    logic               obstacle_event;
  } dss_result_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] entry_time;
  } dss_state_t;

  typedef struct packed {
    logic [14:0] motion_threshold;
    logic [15:0] obstacle_hold_ms;
  } dss_cfg_t;

endpackage

### hdl/dss_step.sv
// Per-tick transition logic of the drive safety supervisor (combinational).
// Depends on dss_pkg for item, state, config and result types.
`timescale 1ns / 1ps

module dss_step (
  input  dss_pkg::dss_item_t   item_i,
  input  dss_pkg::dss_state_t  state_i,
  input  dss_pkg::dss_cfg_t    cfg_i,
  output dss_pkg::dss_state_t  state_o,
  output dss_pkg::dss_result_t result_o
);
  import dss_pkg::*;

  logic [3:0]         mode_boot;    // after the boot step
  logic [3:0]         mode_alert;   // after the bumper alert step
  logic [3:0]         mode_final;
  logic [31:0]        entry_alert;
  logic               alert_take;
  logic signed [17:0] lim;
  logic signed [17:0] lim_neg;
  logic signed [17:0] sum;
  logic signed [17:0] diff;
  logic [3:0]         mode_class;
  logic [16:0]        mag_l;
  logic [16:0]        mag_r;
  logic [31:0]        elapsed;
  logic               release_ok;
  logic               drive_on;

  // Boot leaves for fault or disabled, then alerts preempt non-fault modes
  always_comb begin
    mode_boot = (state_i.mode == ModeBoot)
              ? (item_i.subsystem_fault ? ModeFault : ModeDisabled)
              : state_i.mode;
    alert_take = (item_i.bumper_alert_mask != 8'd0) && (mode_boot < ModeFault);
    mode_alert = alert_take ? ModeObstacle : mode_boot;
    entry_alert = ((mode_boot != state_i.mode) || (mode_alert != mode_boot))
                ? item_i.time_ms : state_i.entry_time;
  end

  // Request classification: wheel difference first, then wheel sum
  always_comb begin
    lim     = $signed({2'b00, cfg_i.motion_threshold, 1'b0});
    lim_neg = -lim;
    sum  = $signed({{2{item_i.request_left[15]}}, item_i.request_left})
         + $signed({{2{item_i.request_right[15]}}, item_i.request_right});
    diff = $signed({{2{item_i.request_left[15]}}, item_i.request_left})
         - $signed({{2{item_i.request_right[15]}}, item_i.request_right});
    priority if (diff > lim) begin
      mode_class = ModeRight;
    end else if (diff < lim_neg) begin
      mode_class = ModeLeft;
    end else if (sum > lim) begin
      mode_class = ModeForward;
    end else if (sum < lim_neg) begin
      mode_class = ModeReverse;
    end else begin
      mode_class = ModeReady;
    end
  end

  // Obstacle release: hold elapsed, bumpers and activation released, neutral
  always_comb begin
    mag_l = item_i.request_left[15]
          ? 17'(-$signed({item_i.request_left[15], item_i.request_left}))
          : {1'b0, item_i.request_left};
    mag_r = item_i.request_right[15]
          ? 17'(-$signed({item_i.request_right[15], item_i.request_right}))
          : {1'b0, item_i.request_right};
    elapsed = item_i.time_ms - entry_alert;
    release_ok = (elapsed >= {16'd0, cfg_i.obstacle_hold_ms}) && item_i.bumpers_released
               && !item_i.activation
               && (mag_l <= {2'b00, cfg_i.motion_threshold})
               && (mag_r <= {2'b00, cfg_i.motion_threshold});
  end

  // Mode-dependent step
  always_comb begin
    mode_final = mode_alert;
    drive_on   = 1'b0;
    unique case (mode_alert)
      ModeDisabled: begin
        if (item_i.activation) mode_final = ModeReady;
      end
      ModeReady, ModeForward, ModeReverse, ModeLeft, ModeRight: begin
        if (item_i.activation) begin
          mode_final = mode_class;
          drive_on   = 1'b1;
        end else begin
          mode_final = ModeDisabled;
        end
      end
      ModeObstacle: begin
        if (release_ok) mode_final = ModeDisabled;
      end
      default: begin
        mode_final = mode_alert;  // fault and unused codes hold
      end
    endcase
  end

  // Next state and result
  always_comb begin
    state_o.mode       = mode_final;
    state_o.entry_time = (mode_final != mode_alert) ? item_i.time_ms : entry_alert;

    result_o.mode           = mode_final;
    result_o.drive_left     = drive_on ? item_i.request_left : 16'sd0;
    result_o.drive_right    = drive_on ? item_i.request_right : 16'sd0;
    result_o.drive_enable   = drive_on;
    result_o.mode_changed   = (mode_final != state_i.mode);
    result_o.obstacle_event = alert_take;
  end

endmodule

### hdl/drive_safety_supervisor.sv
// A request accepted into the input stage (item_q) moves on to the result register (res_q) when it advances.
// Throughput: one request per cycle while the output is not stalled; the mode and entry-time registers close
// a loop through dss_step, and output stalls backpressure via the input stage.
// Reset (rst_ni low, asynchronous): mode boot, entry time zero, both stages empty,
// motion_threshold 50, obstacle_hold_ms 1000. Top level; depends on dss_pkg and dss_step.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module drive_safety_supervisor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dss_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [dss_pkg::CfgDataW-1:0]        cfg_data_i,
  // Tick stream in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // time_ms[31:0], subsystem_fault[32], bumper_alert_mask[40:33], bumpers_released[41],
  // activation[42], request_left[58:43], request_right[74:59], zero pad[79:75]
  input  logic [dss_pkg::InDataW-1:0]         s_axis_tdata,
  // Result stream out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // mode[3:0], drive_left[19:4], drive_right[35:20], drive_enable[36],
  // mode_changed[37], obstacle_event[38], zero pad[39]
  output logic [dss_pkg::OutDataW-1:0]        m_axis_tdata
);
  import dss_pkg::*;

  dss_cfg_t    cfg_q;
  dss_item_t   item_d, item_q;
  logic        in_valid_q;
  logic        out_valid_q;
  dss_state_t  state_q, state_next;
  dss_result_t res_step, res_q;
  logic        in_take;
  logic        advance;

  // Configuration registers; out-of-range indexes are ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_threshold <= ThresholdReset;
      cfg_q.obstacle_hold_ms <= HoldReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegMotionThreshold) cfg_q.motion_threshold <= cfg_data_i[14:0];
      if (cfg_index_i == RegObstacleHoldMs)  cfg_q.obstacle_hold_ms <= cfg_data_i[15:0];
    end
  end

  // Handshake: input stage drains into the result register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Unpack incoming tick
  always_comb begin
    item_d.time_ms           = s_axis_tdata[31:0];
    item_d.subsystem_fault   = s_axis_tdata[32];
    item_d.bumper_alert_mask = s_axis_tdata[40:33];
    item_d.bumpers_released  = s_axis_tdata[41];
    item_d.activation        = s_axis_tdata[42];
    item_d.request_left      = $signed(s_axis_tdata[58:43]);
    item_d.request_right     = $signed(s_axis_tdata[74:59]);
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) item_q <= item_d;
  end

  dss_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_next),
    .result_o (res_step)
  );

  // Supervisor state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode       <= ModeBoot;
      state_q.entry_time <= 32'd0;
      out_valid_q        <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_next;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_step;
  end

  // Pack result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.obstacle_event, res_q.mode_changed, res_q.drive_enable,
                          res_q.drive_right, res_q.drive_left, res_q.mode};

  // Checks
  `DSS_ASSERT_IMP(a_enable_in_drive_mode, out_valid_q && res_q.drive_enable,
    (res_q.mode >= ModeReady) && (res_q.mode <= ModeRight), "enable outside driving mode")
  `DSS_ASSERT_IMP(a_stopped_zero, out_valid_q && !res_q.drive_enable,
    (res_q.drive_left == 16'sd0) && (res_q.drive_right == 16'sd0), "nonzero demand when stopped")
  `DSS_ASSERT_IMP(a_event_obstacle, out_valid_q && res_q.obstacle_event,
    (res_q.mode == ModeObstacle) || (res_q.mode == ModeDisabled), "event without obstacle path")
  `DSS_ASSERT_NXT(a_fault_terminal, state_q.mode == ModeFault,
    state_q.mode == ModeFault, "left fault mode")
  `DSS_ASSERT_NXT(a_state_holds_idle, !advance,
    state_q == $past(state_q), "state moved without a request")

endmodule
